// File: hdl/assert_macros.svh
// Assertion macros shared by the line interleaver RTL.
// Depends on nothing; every user module provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside of reset.
`define EPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that one condition implies another in the next cycle.
`define EPD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define EPD_ASSERT(lbl, prop, msg)
`define EPD_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// File: hdl/epd_pkg.sv
// Shared constants, types and the bit weaving function of the line interleaver.
// Depends on nothing.
`default_nettype none

package epd_pkg;

	localparam int LineBytes  = 34;
	localparam int HalfPixels = 132;
	localparam int OutBytes   = (2 * HalfPixels) / 8;
	localparam int EvenBase   = LineBytes / 2;
	localparam int MemDepth   = 2 * LineBytes;
	localparam int PosW       = $clog2(LineBytes);
	localparam int AddrW      = $clog2(MemDepth);
	localparam int HalfW      = $clog2(EvenBase);

	typedef logic [PosW-1:0]  pos_t;
	typedef logic [AddrW-1:0] addr_t;
	typedef logic [HalfW-1:0] half_t;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_SOF   = 1'b1
	} op_t;

	// Write request from the front into the line buffer.
	typedef struct packed {
		logic       en;
		logic       bank;
		pos_t       idx;
		logic [7:0] data;
		logic       commit;
	} wr_req_t;

	// Read request from the back; half selects the byte pair of one output byte.
	typedef struct packed {
		logic  en;
		logic  bank;
		half_t half;
		logic  done;
	} rd_req_t;

	// Flat buffer address of a byte within one of the two line banks.
	function automatic addr_t line_addr(input logic bank, input pos_t idx);
		addr_t base;
		base = bank ? addr_t'(LineBytes) : '0;
		return base + addr_t'(idx);
	endfunction

	// Even output bits take the second half nibble, odd bits the first one.
	function automatic logic [7:0] weave(input logic [3:0] odd_n, input logic [3:0] even_n);
		logic [7:0] r;
		for (int i = 0; i < 4; i++) begin
			r[2*i+1] = even_n[i];
			r[2*i]   = odd_n[i];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/epd_if.sv
// Valid/ready channel interfaces for pixel input and panel byte output.
// Depends on nothing.
`default_nettype none

interface epd_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] pixel_byte;

	modport source (output valid, output op, output pixel_byte, input ready);
	modport sink (input valid, input op, input pixel_byte, output ready);
endinterface

interface epd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_line;

	modport source (output valid, output out_byte, output last_of_line, input ready);
	modport sink (input valid, input out_byte, input last_of_line, output ready);
endinterface

`default_nettype wire

// File: hdl/epd_front.sv
// Input front: accepts pixel and start-of-frame items and fills the line banks.
// Depends on epd_pkg, epd_if and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module epd_front
	import epd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	epd_in_if.sink       in_ch,
	input  wire logic [1:0] full,
	output wr_req_t      wr
);

	pos_t pos_q;
	logic wb_q;
	logic accept;
	logic is_sof;
	logic line_end;

	// The bank being filled must have been drained by the back.
	assign in_ch.ready = !full[wb_q];
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_sof      = op_t'(in_ch.op) == OP_SOF;
	assign line_end    = pos_q == pos_t'(LineBytes - 1);

	// Write request; the last byte of a line hands the bank to the back.
	always_comb begin
		wr.en     = accept && !is_sof;
		wr.bank   = wb_q;
		wr.idx    = pos_q;
		wr.data   = in_ch.pixel_byte;
		wr.commit = accept && !is_sof && line_end;
	end

	// Line position and bank select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			wb_q  <= 1'b0;
		end else if (accept) begin
			if (is_sof) begin
				pos_q <= '0;
			end else if (line_end) begin
				pos_q <= '0;
				wb_q  <= !wb_q;
			end else begin
				pos_q <= pos_q + pos_t'(1);
			end
		end
	end

	`EPD_ASSERT(a_pos_range, pos_q < pos_t'(LineBytes), "line position out of range")

endmodule

`default_nettype wire

// File: hdl/epd_lbuf.sv
// Two-bank line buffer with bank occupancy flags, the queue between front and back.
// Depends on epd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module epd_lbuf
	import epd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire wr_req_t    wr,
	input  wire rd_req_t    rd,
	output logic [1:0]      full,
	output logic [7:0]      rd_a_s1,
	output logic [7:0]      rd_b_s1
);

	logic [7:0] mem [MemDepth];
	logic [1:0] full_q;
	addr_t      addr_w;
	addr_t      addr_a;
	addr_t      addr_b;

	assign addr_w = line_addr(wr.bank, wr.idx);
	assign addr_a = line_addr(rd.bank, pos_t'(rd.half));
	assign addr_b = line_addr(rd.bank, pos_t'(rd.half) + pos_t'(EvenBase));
	assign full   = full_q;

	// Storage write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[addr_w] <= wr.data;
		end
	end

	// Two registered read ports: first-half byte and second-half byte.
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_a_s1 <= mem[addr_a];
			rd_b_s1 <= mem[addr_b];
		end
	end

	// A bank is full from its last write until the back has read it out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else begin
			if (wr.commit) begin
				full_q[wr.bank] <= 1'b1;
			end
			if (rd.done) begin
				full_q[rd.bank] <= 1'b0;
			end
		end
	end

	`EPD_ASSERT(a_wr_free, !wr.en || !full_q[wr.bank], "write into a bank still held")
	`EPD_ASSERT(a_rd_full, !rd.en || full_q[rd.bank], "read from a bank not yet filled")
	`EPD_ASSERT_NEXT(a_done_clears, rd.done && !wr.commit, !full_q[$past(rd.bank)], "bank not freed")

endmodule

`default_nettype wire

// File: hdl/epd_back.sv
// Output back: walks a filled line, weaves the bit halves and drives the output channel.
// Depends on epd_pkg and epd_if.
`default_nettype none

module epd_back
	import epd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] full,
	input  wire logic [7:0] rd_a_s1,
	input  wire logic [7:0] rd_b_s1,
	output rd_req_t         rd,
	epd_out_if.source       out_ch
);

	pos_t       j_q;
	logic       rb_q;
	logic       valid_s1;
	logic       odd_s1;
	logic       last_s1;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_adv;
	logic       s1_adv;
	logic       issue;
	logic       last_j;
	logic [3:0] nib_a;
	logic [3:0] nib_b;

	// Stage advance, from the output register backwards.
	assign out_adv = !out_valid_q || out_ch.ready;
	assign s1_adv  = !valid_s1 || out_adv;
	assign issue   = full[rb_q] && s1_adv;
	assign last_j  = j_q == pos_t'(OutBytes - 1);

	// Each output byte reads one byte from each half of the line.
	always_comb begin
		rd.en   = issue;
		rd.bank = rb_q;
		rd.half = j_q[PosW-1:1];
		rd.done = issue && last_j;
	end

	// Output byte counter and bank select.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q      <= '0;
			rb_q     <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			if (s1_adv) begin
				valid_s1 <= issue;
			end
			if (issue) begin
				if (last_j) begin
					j_q  <= '0;
					rb_q <= !rb_q;
				end else begin
					j_q <= j_q + pos_t'(1);
				end
			end
		end
	end

	// Read stage side information.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			odd_s1  <= j_q[0];
			last_s1 <= last_j;
		end
	end

	// Even output bytes use the high nibbles, odd ones the low nibbles.
	assign nib_a = odd_s1 ? rd_a_s1[3:0] : rd_a_s1[7:4];
	assign nib_b = odd_s1 ? rd_b_s1[3:0] : rd_b_s1[7:4];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			out_byte_q <= weave(nib_a, nib_b);
			out_last_q <= last_s1;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_byte     = out_byte_q;
	assign out_ch.last_of_line = out_last_q;

endmodule

`default_nettype wire

// File: hdl/epd_line_bit_interleaver_unit.sv
// Top level of the panel line bit interleaver.
// Depends on epd_pkg, epd_if, epd_front, epd_lbuf and epd_back.
//
// Usage: in_ch carries items {op, pixel_byte}; op selects a pixel byte or a
// start of frame. Thirty-four pixel bytes, first pixel in the MSB, make one
// line. A start of frame drops any partial line and restarts at byte 0; it
// produces no output. When a line is complete, out_ch delivers 33 reordered
// bytes, one per cycle while out_ch.ready is high, with last_of_line set on
// the 33rd. A transfer is a cycle with valid and ready high on the channel.
// Output path: a completed line sets its bank flag; each of its bytes then passes
// the read stage and the output register. Throughput: one input and one output
// byte per cycle when neither channel stalls; two line banks let a new line fill
// as the last drains, so the 34 input bytes of each line stream without gaps.
// Stall: if out_ch.ready stays low, the output register holds its byte; input
// is taken until the front reaches a bank still held by the back, then in_ch
// ready drops until that bank is read out.
// Reset: arst_n clears the line position, the bank flags and the output valid;
// no output is pending after reset and no clearing pass is needed.
`default_nettype none

module epd_line_bit_interleaver_unit
	import epd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	epd_in_if.sink    in_ch,
	epd_out_if.source out_ch
);

	wr_req_t    wr;
	rd_req_t    rd;
	logic [1:0] full;
	logic [7:0] rd_a_s1;
	logic [7:0] rd_b_s1;

	epd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.full   (full),
		.wr     (wr)
	);

	epd_lbuf u_lbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.rd      (rd),
		.full    (full),
		.rd_a_s1 (rd_a_s1),
		.rd_b_s1 (rd_b_s1)
	);

	epd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.full    (full),
		.rd_a_s1 (rd_a_s1),
		.rd_b_s1 (rd_b_s1),
		.rd      (rd),
		.out_ch  (out_ch)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb_epd_line_bit_interleaver_unit.sv
// Self-checking testbench for the panel line bit interleaver unit.
// Depends on epd_pkg, epd_if and the RTL of epd_line_bit_interleaver_unit.
`timescale 1ns / 100ps

module tb_epd_line_bit_interleaver_unit
	import epd_pkg::*;
();

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} panel_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	epd_in_if  in_ch();
	epd_out_if out_ch();

	epd_line_bit_interleaver_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Predicted line contents and the panel bytes still owed by the block.
	logic [7:0]  line_copy [LineBytes];
	int unsigned fill_pos;
	panel_byte_t panel_q [$];

	// Idle control for both sides; a hold request stalls the receiver.
	bit tx_idle_on;
	bit rx_idle_on;
	int rx_hold_req;
	int rx_hold_left;

	int unsigned mismatches;
	int unsigned bytes_checked;
	int unsigned lines_checked;
	int unsigned items_sent;
	int unsigned frames_started;

	always #5 clk = ~clk;

	// Read one bit of the predicted line; bit 0 is the MSB of byte 0.
	function automatic logic line_bit(int unsigned k);
		return line_copy[k / 8][7 - (k % 8)];
	endfunction

	// Track one accepted item and queue the panel bytes that a full line produces.
	task automatic track_item(op_t op, logic [7:0] data);
		panel_byte_t pb;
		logic [7:0]  v;
		int unsigned p;
		int unsigned src;
		if (op == OP_SOF) begin
			fill_pos = 0;
			frames_started++;
			return;
		end
		line_copy[fill_pos] = data;
		fill_pos++;
		if (fill_pos < LineBytes)
			return;
		fill_pos = 0;
		// Odd output bits take the first half, even bits the second half.
		for (int j = 0; j < OutBytes; j++) begin
			for (int b = 0; b < 8; b++) begin
				p = j * 8 + b;
				src = (p % 2) ? (p - 1) / 2 : p / 2 + LineBytes * 4;
				v[7 - b] = line_bit(src);
			end
			pb.data = v;
			pb.last = (j == OutBytes - 1);
			panel_q.push_back(pb);
		end
	endtask

	// Offer one item, wait for its transfer, then predict its effect.
	task automatic send_item(op_t op, logic [7:0] data);
		while (tx_idle_on && $urandom_range(99) < 34) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.op         <= op;
		in_ch.pixel_byte <= data;
		do
			@(posedge clk);
		while (!in_ch.ready);
		items_sent++;
		track_item(op, data);
	endtask

	// Send a line of random bytes; with break_at below the line length a start
	// of frame cuts the line short at that byte.
	task automatic send_line(int unsigned break_at);
		for (int unsigned i = 0; i < LineBytes; i++) begin
			if (i == break_at) begin
				send_item(OP_SOF, 8'($urandom));
				return;
			end
			send_item(OP_PIXEL, 8'($urandom));
		end
	endtask

	// Stop offering and wait until every predicted panel byte has been checked.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (panel_q.size() != 0)
			@(posedge clk);
	endtask

	// Receiver side: random stalls, a counted hold-off on request, or always ready.
	always @(posedge clk) begin
		if (rx_hold_req != 0) begin
			rx_hold_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ch.ready <= 1'b0;
		end else if (rx_idle_on) begin
			out_ch.ready <= ($urandom_range(99) >= 34);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Compare each output transfer with the oldest predicted panel byte.
	always @(posedge clk) begin
		panel_byte_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (panel_q.size() == 0) begin
				$display("%0t: unexpected output byte %h last %b", $time,
					out_ch.out_byte, out_ch.last_of_line);
				mismatches++;
			end else begin
				want = panel_q.pop_front();
				bytes_checked++;
				if (want.last)
					lines_checked++;
				if (out_ch.out_byte !== want.data) begin
					$display("%0t: out_byte expected %h actual %h", $time,
						want.data, out_ch.out_byte);
					mismatches++;
				end
				if (out_ch.last_of_line !== want.last) begin
					$display("%0t: last_of_line expected %b actual %b", $time,
						want.last, out_ch.last_of_line);
					mismatches++;
				end
			end
		end
	end

	// Start of frame with both data extremes, and a partial line that is dropped.
	task automatic test_sof_and_partial();
		send_item(OP_SOF, 8'hFF);
		for (int i = 0; i < 5; i++)
			send_item(OP_PIXEL, 8'hFF);
		send_item(OP_SOF, 8'h00);
		send_item(OP_SOF, 8'hA5);
	endtask

	// One line with fixed patterns: extremes, walking bits and set dropped bits.
	task automatic test_directed_line();
		logic [7:0] d;
		for (int i = 0; i < LineBytes; i++) begin
			if (i == 0)
				d = 8'hFF;
			else if (i == LineBytes / 2 - 1 || i == LineBytes - 1)
				d = 8'h0F;
			else if (i == LineBytes / 2)
				d = 8'h00;
			else if (i % 2)
				d = 8'h80 >> (i % 8);
			else
				d = ~(8'h01 << (i % 8));
			send_item(OP_PIXEL, d);
		end
		send_item(OP_SOF, 8'h00);
	endtask

	// A back-to-back line with no idling on either side.
	task automatic test_streaming();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_line(LineBytes);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Random lines with random gaps; some lines are cut short by a start of frame.
	task automatic test_random_lines();
		repeat (2) begin
			if ($urandom_range(3) == 0)
				send_line($urandom_range(LineBytes - 1));
			if ($urandom_range(2) == 0)
				send_item(OP_SOF, 8'($urandom));
			send_line(LineBytes);
		end
	endtask

	// Long receiver hold-off while the sender keeps offering, so both banks fill.
	task automatic test_stall_fill();
		tx_idle_on = 1'b0;
		rx_hold_req = 300;
		send_line(LineBytes);
		send_line(LineBytes);
		for (int i = 0; i < 12; i++)
			send_item(OP_PIXEL, 8'($urandom));
		send_item(OP_SOF, 8'($urandom));
		tx_idle_on = 1'b1;
	endtask

	// Sender waits until every panel byte is out before the next line.
	task automatic test_drain_pause();
		wait_drained();
		send_line(LineBytes);
	endtask

	initial begin
		in_ch.valid      <= 1'b0;
		in_ch.op         <= OP_PIXEL;
		in_ch.pixel_byte <= 8'h00;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		rx_hold_req = 0;
		fill_pos = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_sof_and_partial();
		test_directed_line();
		test_streaming();
		test_random_lines();
		test_stall_fill();
		test_drain_pause();

		in_ch.valid <= 1'b0;
		wait_drained();
		repeat (10) @(posedge clk);

		$display("Sent %0d items with %0d starts of frame; checked %0d panel bytes in %0d lines.",
			items_sent, frames_started, bytes_checked, lines_checked);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#2000000;
		$display("Timeout with %0d panel bytes still expected.", panel_q.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
